FILE: hw/rtl/isodate_pkg.sv
// Shared constants, the parsed-field record type and its width for the ISO date block.
package isodate_pkg;

    // Default configuration values handed down from the top level.
    localparam int MAX_YEAR_DIGITS_DEF = 7;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Field widths fixed by the result format.
    localparam int YEAR_W  = 24;
    localparam int MONTH_W = 7;
    localparam int DAY_W   = 7;
    localparam int USED_W  = 4;
    localparam int MOD25_W = 5;

    // Year magnitude limits; the accumulator saturates one past the upper limit.
    localparam logic [YEAR_W-1:0] YEAR_MIN_MAG = 24'd5877641;
    localparam logic [YEAR_W-1:0] YEAR_MAX_MAG = 24'd5879610;
    localparam logic [YEAR_W-1:0] YEAR_SAT     = 24'd5879611;

    // One parsed field, handed from the parser to the day-count pipeline.
    typedef struct packed {
        logic                syntax_ok;
        logic                year_neg;
        logic [YEAR_W-1:0]   year_mag;
        logic [MOD25_W-1:0]  year_mod25;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [USED_W-1:0]   used;
    } isodate_rec_t;

    localparam int REC_W = $bits(isodate_rec_t);

endpackage

FILE: hw/rtl/iso_date_text_to_day_number.sv
// ISO date text parser: takes one text byte per word at up to one word per cycle and, on the
// word marked last, gives one result word with the day count from 1970-01-01, a valid flag and
// the number of bytes the date used. The byte parser updates only small accumulators, so it
// takes a byte in every cycle that char_stall is low; each field then passes through a
// QUEUE_DEPTH-entry queue and a four-stage day-count pipeline, and while the output side is
// not stalled, results can follow one another every cycle. char_stall rises only when the
// queue is full, which happens only while result_stall holds the pipeline.
module iso_date_text_to_day_number #(
    parameter int MAX_YEAR_DIGITS = isodate_pkg::MAX_YEAR_DIGITS_DEF,
    parameter int QUEUE_DEPTH     = isodate_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] day_number,
    output logic               date_valid,
    output logic [3:0]         chars_used
);
    import isodate_pkg::*;

    logic         char_accept;
    logic         rec_push;
    isodate_rec_t rec_in;
    isodate_rec_t rec_out;
    logic         rec_pop;
    logic         queue_full;
    logic         queue_empty;

    assign char_stall  = queue_full;
    assign char_accept = char_valid && !queue_full;

    // Byte parser.
    isodate_front #(
        .MAX_YEAR_DIGITS (MAX_YEAR_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .last_char   (last_char),
        .char_accept (char_accept),
        .rec_push    (rec_push),
        .rec_data    (rec_in)
    );

    // Field queue.
    isodate_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Day-count pipeline.
    isodate_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (!queue_empty),
        .rec_data     (rec_out),
        .rec_pop      (rec_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .day_number   (day_number),
        .date_valid   (date_valid),
        .chars_used   (chars_used)
    );

endmodule

FILE: hw/rtl/isodate_front.sv
// Byte-serial date parser: walks the text one byte per word and queues a record per field.
module isodate_front #(
    parameter int MAX_YEAR_DIGITS = isodate_pkg::MAX_YEAR_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 char_code,
    input  logic                       last_char,
    input  logic                       char_accept,
    output logic                       rec_push,
    output isodate_pkg::isodate_rec_t  rec_data
);
    import isodate_pkg::*;

    localparam int DIG_W = $clog2(MAX_YEAR_DIGITS + 1);

    // Parse phase codes.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_YEAR  = 3'd1;
    localparam logic [2:0] PH_MON1  = 3'd2;
    localparam logic [2:0] PH_MON2  = 3'd3;
    localparam logic [2:0] PH_DASH2 = 3'd4;
    localparam logic [2:0] PH_DAY1  = 3'd5;
    localparam logic [2:0] PH_DAY2  = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DASH = 8'h2d;

    logic [2:0]         phase_reg, phase_next;
    logic               failed_reg, failed_next;
    logic               neg_reg, neg_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MOD25_W-1:0] mod25_reg, mod25_next;
    logic [DIG_W-1:0]   digits_reg, digits_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [USED_W-1:0]  used_reg, used_next;

    logic               is_dig;
    logic               is_dash;
    logic [3:0]         dg;
    logic [YEAR_W+3:0]  year_mul;
    logic [USED_W-1:0]  used_inc;

    // Next residue of the year modulo 25 after appending one digit.
    function automatic logic [MOD25_W-1:0] mod25_step(input logic [MOD25_W-1:0] r,
                                                      input logic [3:0] d);
        logic [7:0]  t;
        logic [13:0] q;
        logic [7:0]  rem;
        t   = 8'(r * 4'd10) + 8'(d);
        q   = (14'(t) * 14'd41) >> 10;
        rem = t - 8'(q * 14'd25);
        return rem[MOD25_W-1:0];
    endfunction

    // Byte classification.
    assign is_dig   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_dash  = (char_code == CHAR_DASH);
    assign dg       = char_code[3:0];
    assign year_mul = (YEAR_W+4)'(year_reg) * (YEAR_W+4)'(10) + (YEAR_W+4)'(dg);
    assign used_inc = (used_reg == {USED_W{1'b1}}) ? used_reg : used_reg + 1'b1;

    // Parser state update for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        neg_next    = neg_reg;
        year_next   = year_reg;
        mod25_next  = mod25_reg;
        digits_next = digits_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        used_next   = used_reg;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (is_dash)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_YEAR;
                        used_next  = used_inc;
                    end
                    else if (is_dig)
                    begin
                        year_next   = YEAR_W'(dg);
                        mod25_next  = MOD25_W'(dg);
                        digits_next = DIG_W'(1);
                        phase_next  = PH_YEAR;
                        used_next   = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_YEAR:
                begin
                    if (is_dig && (digits_reg < DIG_W'(MAX_YEAR_DIGITS)))
                    begin
                        year_next   = (year_mul > (YEAR_W+4)'(YEAR_SAT)) ?
                                      YEAR_SAT : year_mul[YEAR_W-1:0];
                        mod25_next  = mod25_step(mod25_reg, dg);
                        digits_next = digits_reg + 1'b1;
                        used_next   = used_inc;
                    end
                    else if (is_dash && (digits_reg != '0))
                    begin
                        phase_next = PH_MON1;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_MON1:
                begin
                    if (is_dig)
                    begin
                        month_next = MONTH_W'(dg);
                        phase_next = PH_MON2;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_MON2:
                begin
                    if (is_dig)
                    begin
                        month_next = MONTH_W'(month_reg * 4'd10) + MONTH_W'(dg);
                        phase_next = PH_DASH2;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_DASH2:
                begin
                    if (is_dash)
                    begin
                        phase_next = PH_DAY1;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_DAY1:
                begin
                    if (is_dig)
                    begin
                        day_next   = DAY_W'(dg);
                        phase_next = PH_DAY2;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_DAY2:
                begin
                    if (is_dig)
                    begin
                        day_next   = DAY_W'(day_reg * 4'd10) + DAY_W'(dg);
                        phase_next = PH_DONE;
                        used_next  = used_inc;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    // Trailing bytes after the day are left to the caller.
                end
            endcase
        end
    end

    // The record of a field is taken from the state after its final byte.
    always_comb
    begin
        rec_push            = char_accept && last_char;
        rec_data.syntax_ok  = !failed_next && (phase_next == PH_DONE);
        rec_data.year_neg   = neg_next;
        rec_data.year_mag   = year_next;
        rec_data.year_mod25 = mod25_next;
        rec_data.month      = month_next;
        rec_data.day        = day_next;
        rec_data.used       = used_next;
    end

    // Parser registers; the final byte of a field returns them to the start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            failed_reg <= 1'b0;
            neg_reg    <= 1'b0;
            year_reg   <= '0;
            mod25_reg  <= '0;
            digits_reg <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            used_reg   <= '0;
        end
        else if (char_accept)
        begin
            if (last_char)
            begin
                phase_reg  <= PH_START;
                failed_reg <= 1'b0;
                neg_reg    <= 1'b0;
                year_reg   <= '0;
                mod25_reg  <= '0;
                digits_reg <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                used_reg   <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                failed_reg <= failed_next;
                neg_reg    <= neg_next;
                year_reg   <= year_next;
                mod25_reg  <= mod25_next;
                digits_reg <= digits_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                used_reg   <= used_next;
            end
        end
    end

endmodule

FILE: hw/rtl/isodate_fifo.sv
// Small register queue that decouples the parser from the day-count pipeline.
module isodate_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/isodate_back.sv
// Day-count pipeline: range checks, then days from 1970-01-01 over four register stages.
module isodate_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rec_valid,
    input  isodate_pkg::isodate_rec_t  rec_data,
    output logic                       rec_pop,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [31:0]         day_number,
    output logic                       date_valid,
    output logic [3:0]                 chars_used
);
    import isodate_pkg::*;

    localparam int YS_W   = YEAR_W + 1;
    localparam int DAYS_W = 34;
    localparam int DOY_W  = 9;
    localparam int Q_W    = 22;
    localparam int PROD_W = 45;
    localparam int C_W    = 18;
    // floor(u / 25) = (u * RECIP_25) >> RECIP_SHIFT for every u below 2^22.
    localparam int                RECIP_SHIFT = 27;
    localparam logic [22:0]       RECIP_25    = 23'd5368710;
    // Offset that keeps the quarter year non-negative before the divide.
    localparam logic signed [YS_W-1:0] Q_OFFSET = 25'sd1500000;
    localparam logic signed [C_W-1:0]  C_OFFSET = 18'sd60000;
    localparam logic signed [DAYS_W-1:0] EPOCH_SHIFT = 34'sd719468;
    localparam logic signed [31:0] DAY_FAIL = 32'sh80000000;

    // Days in a month, with February following the leap flag.
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            7'd2:                              len = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:           len = 5'd30;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8,
            7'd10, 7'd12:                      len = 5'd31;
            default:                           len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a year that starts in March.
    function automatic logic [DOY_W-1:0] march_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] off;
        case (m)
            7'd1:    off = 9'd306;
            7'd2:    off = 9'd337;
            7'd3:    off = 9'd0;
            7'd4:    off = 9'd31;
            7'd5:    off = 9'd61;
            7'd6:    off = 9'd92;
            7'd7:    off = 9'd122;
            7'd8:    off = 9'd153;
            7'd9:    off = 9'd184;
            7'd10:   off = 9'd214;
            7'd11:   off = 9'd245;
            7'd12:   off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    logic                     adv;

    // Stage 1 registers.
    logic                     s1_vld_reg;
    logic                     s1_ok_reg, s1_ok_next;
    logic signed [YS_W-1:0]   s1_ys_reg, s1_ys_next;
    logic [DOY_W-1:0]         s1_doy_reg, s1_doy_next;
    logic [USED_W-1:0]        s1_used_reg;

    // Stage 2 registers.
    logic                     s2_vld_reg;
    logic                     s2_ok_reg;
    logic signed [YS_W-1:0]   s2_q_reg, s2_q_next;
    logic [PROD_W-1:0]        s2_prod_reg, s2_prod_next;
    logic signed [DAYS_W-1:0] s2_m365_reg, s2_m365_next;
    logic [DOY_W-1:0]         s2_doy_reg;
    logic [USED_W-1:0]        s2_used_reg;

    // Stage 3 registers.
    logic                     s3_vld_reg;
    logic                     s3_ok_reg;
    logic signed [C_W-1:0]    s3_c_reg, s3_c_next;
    logic signed [DAYS_W-1:0] s3_part_reg, s3_part_next;
    logic [USED_W-1:0]        s3_used_reg;

    // Output registers.
    logic                     out_vld_reg;
    logic signed [31:0]       out_days_reg, out_days_next;
    logic                     out_ok_reg;
    logic [USED_W-1:0]        out_used_reg;

    logic                     leap;
    logic [YEAR_W-1:0]        year_lim;
    logic [4:0]               mlen;
    logic signed [YS_W-1:0]   ys_signed;
    logic signed [YS_W-1:0]   u_wide;
    logic signed [DAYS_W-1:0] c_wide;

    // The whole pipeline moves whenever the output register is free or being taken.
    assign adv     = !out_vld_reg || !result_stall;
    assign rec_pop = adv && rec_valid;

    // Stage 1: field checks and the March-based year and day of year.
    always_comb
    begin
        leap       = (rec_data.year_mag[1:0] == 2'd0) &&
                     ((rec_data.year_mod25 != '0) || (rec_data.year_mag[3:0] == 4'd0));
        year_lim   = rec_data.year_neg ? YEAR_MIN_MAG : YEAR_MAX_MAG;
        mlen       = month_len(rec_data.month, leap);
        s1_ok_next = rec_data.syntax_ok && (rec_data.year_mag <= year_lim) &&
                     (mlen != 5'd0) && (rec_data.day != '0) &&
                     (rec_data.day <= DAY_W'(mlen));
        ys_signed  = rec_data.year_neg ? -$signed({1'b0, rec_data.year_mag})
                                       :  $signed({1'b0, rec_data.year_mag});
        s1_ys_next = (rec_data.month <= MONTH_W'(2)) ? ys_signed - YS_W'(1) : ys_signed;
        s1_doy_next = march_offset(rec_data.month) + DOY_W'(rec_data.day) - DOY_W'(1);
    end

    // Stage 2: quarter year, reciprocal product for the century count, and 365 * year.
    always_comb
    begin
        s2_q_next    = s1_ys_reg >>> 2;
        u_wide       = s2_q_next + Q_OFFSET;
        s2_prod_next = PROD_W'(u_wide[Q_W-1:0]) * PROD_W'(RECIP_25);
        s2_m365_next = DAYS_W'(s1_ys_reg) * DAYS_W'(365);
    end

    // Stage 3: century count and the sum of the year terms and the day of year with the epoch shift.
    always_comb
    begin
        s3_c_next    = $signed({1'b0, s2_prod_reg[RECIP_SHIFT +: C_W-1]}) - C_OFFSET;
        s3_part_next = s2_m365_reg + DAYS_W'(s2_q_reg) +
                       $signed({{(DAYS_W-DOY_W){1'b0}}, s2_doy_reg}) - EPOCH_SHIFT;
    end

    // Output stage: subtract the century term, add the 400-year term, keep the low 32 bits.
    always_comb
    begin
        c_wide        = DAYS_W'(s3_c_reg);
        out_days_next = 32'(s3_part_reg - c_wide + (c_wide >>> 2));
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= rec_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_ys_reg    <= s1_ys_next;
            s1_doy_reg   <= s1_doy_next;
            s1_used_reg  <= rec_data.used;

            s2_ok_reg    <= s1_ok_reg;
            s2_q_reg     <= s2_q_next;
            s2_prod_reg  <= s2_prod_next;
            s2_m365_reg  <= s2_m365_next;
            s2_doy_reg   <= s1_doy_reg;
            s2_used_reg  <= s1_used_reg;

            s3_ok_reg    <= s2_ok_reg;
            s3_c_reg     <= s3_c_next;
            s3_part_reg  <= s3_part_next;
            s3_used_reg  <= s2_used_reg;

            out_ok_reg   <= s3_ok_reg;
            out_days_reg <= s3_ok_reg ? out_days_next : DAY_FAIL;
            out_used_reg <= s3_ok_reg ? s3_used_reg : '0;
        end
    end

    assign result_valid = out_vld_reg;
    assign day_number   = out_days_reg;
    assign date_valid   = out_ok_reg;
    assign chars_used   = out_used_reg;

endmodule

FILE: hw/rtl/isodate_checker.sv
// Port-level checks for the ISO date parser, bound to the top level.
module isodate_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               char_valid,
    input logic               char_stall,
    input logic [7:0]         char_code,
    input logic               last_char,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] day_number,
    input logic               date_valid,
    input logic [3:0]         chars_used
);
    // A stalled result word holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(day_number) &&
                                         $stable(date_valid) && $stable(chars_used))
        else $error("stalled result word changed");

    // A failed field reports the fixed failure value and no consumed bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !date_valid |-> (day_number == 32'sh80000000) && (chars_used == 4'd0))
        else $error("failed result word carries data");

    // A valid date uses at least seven bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && date_valid |-> (chars_used >= 4'd7))
        else $error("valid date with too few bytes");

    // Input is stalled only while the output side holds a waiting word.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && $past(result_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind iso_date_text_to_day_number isodate_checker u_isodate_checker (.*);

FILE: tb/sv/iso_date_text_to_day_number_test.sv
// Self-checking testbench for the ISO date text to day number block.
module iso_date_text_to_day_number_test;

    import isodate_pkg::*;

    localparam int YEAR_DIGITS = MAX_YEAR_DIGITS_DEF;
    localparam int RANDOM_BYTES = 1130;

    localparam logic [7:0] DASH_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] NINE_CHAR = 8'h39;
    localparam logic [7:0] NUL_CHAR  = 8'h00;
    localparam logic signed [31:0] NO_DATE = 32'sh8000_0000;

    // Where the byte scanner stands within one field.
    typedef enum logic [3:0] {
        AT_START, IN_YEAR, AT_MON1, AT_MON2, AT_DASH2, AT_DAY1, AT_DAY2, AT_DONE
    } scan_phase_e;

    typedef struct packed {
        logic signed [31:0] day;
        logic               ok;
        logic [3:0]         used;
    } date_result_t;

    // One directed field; an empty text stands for a single NUL byte.
    typedef struct {
        string              text;
        bit                 typed;
        logic signed [31:0] day;
        logic               ok;
        logic [3:0]         used;
    } date_case_t;

    localparam int NUM_CASES = 26;

    date_case_t date_cases [NUM_CASES] = '{
        '{"1970-01-01",       1, 0,       1, 10},
        '{"1970-01-02",       1, 1,       1, 10},
        '{"1969-12-31",       1, -1,      1, 10},
        '{"2000-02-29",       0, 0,       0, 0},
        '{"1900-02-29",       1, NO_DATE, 0, 0},
        '{"2024-02-30",       1, NO_DATE, 0, 0},
        '{"2023-13-01",       1, NO_DATE, 0, 0},
        '{"2023-00-10",       1, NO_DATE, 0, 0},
        '{"2023-04-31",       1, NO_DATE, 0, 0},
        '{"2023-01-00",       1, NO_DATE, 0, 0},
        '{"2023-01-1",        1, NO_DATE, 0, 0},
        '{"2023-01-15T12:00", 0, 0,       0, 0},
        '{"5879610-07-11",    0, 0,       0, 0},
        '{"5879610-12-31",    0, 0,       0, 0},
        '{"-5877641-06-23",   0, 0,       0, 0},
        '{"-5877641-01-01",   0, 0,       0, 0},
        '{"5879611-01-01",    1, NO_DATE, 0, 0},
        '{"-5877642-01-01",   1, NO_DATE, 0, 0},
        '{"9999999-01-01",    1, NO_DATE, 0, 0},
        '{"12345678-01-01",   1, NO_DATE, 0, 0},
        '{"0-01-01",          0, 0,       0, 0},
        '{"-0-03-01",         0, 0,       0, 0},
        '{"--1-01-01",        1, NO_DATE, 0, 0},
        '{"2020/01/01",       1, NO_DATE, 0, 0},
        '{"\377",             1, NO_DATE, 0, 0},
        '{"",                 1, NO_DATE, 0, 0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               char_valid;
    logic               char_stall;
    logic [7:0]         char_code;
    logic               last_char;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] day_number;
    logic               date_valid;
    logic [3:0]         chars_used;

    int snd_idle;
    int rcv_idle;
    int err_cnt = 0;

    // Scanner state of the prediction, and the dates still owed by the block.
    scan_phase_e  scan_phase;
    int unsigned  year_mag;
    bit           year_neg;
    int unsigned  year_digits;
    int unsigned  month_num;
    int unsigned  day_num;
    int unsigned  used_bytes;
    bit           scan_failed;
    date_result_t pending_dates [$];
    logic [7:0]   field_bytes [$];

    iso_date_text_to_day_number #(
        .MAX_YEAR_DIGITS(YEAR_DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_code(char_code),
        .last_char(last_char),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .day_number(day_number),
        .date_valid(date_valid),
        .chars_used(chars_used)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Length of a month; February follows the Gregorian leap rules.
    function automatic int unsigned month_days(int unsigned ymag, int unsigned m);
        bit leap;
        leap = (ymag % 4 == 0) && ((ymag % 100 != 0) || (ymag % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Days from 1970-01-01 in the proleptic civil calendar, counted in 400-year eras.
    function automatic longint days_from_epoch(longint y, longint m, longint d);
        longint era, yoe, doy, doe;
        if (m <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void clear_scan();
        scan_phase  = AT_START;
        year_mag    = 0;
        year_neg    = 1'b0;
        year_digits = 0;
        month_num   = 0;
        day_num     = 0;
        used_bytes  = 0;
        scan_failed = 1'b0;
    endfunction

    function automatic void count_byte();
        if (used_bytes < 15)
            used_bytes++;
    endfunction

    // Advance the scanner by one byte; on the last byte of a field, work out the date.
    task automatic scan_byte(input logic [7:0] c, input bit last, output bit got,
                             output date_result_t res);
        bit          is_dig;
        bit          is_dash;
        bit          ok;
        int unsigned dg;
        int unsigned v;
        longint      y;
        longint      days;
        is_dig  = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
        is_dash = (c == DASH_CHAR);
        dg      = c - ZERO_CHAR;
        got     = last;
        res     = '0;
        if (!scan_failed)
        begin
            case (scan_phase)
                AT_START:
                    if (is_dash)
                    begin
                        year_neg = 1'b1; scan_phase = IN_YEAR; count_byte();
                    end
                    else if (is_dig)
                    begin
                        year_mag = dg; year_digits = 1; scan_phase = IN_YEAR; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                IN_YEAR:
                    if (is_dig && year_digits < YEAR_DIGITS)
                    begin
                        v = year_mag * 10 + dg;
                        year_mag = (v > YEAR_SAT) ? YEAR_SAT : v;
                        year_digits++;
                        count_byte();
                    end
                    else if (is_dash && year_digits >= 1)
                    begin
                        scan_phase = AT_MON1; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                AT_MON1:
                    if (is_dig)
                    begin
                        month_num = dg; scan_phase = AT_MON2; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                AT_MON2:
                    if (is_dig)
                    begin
                        month_num = month_num * 10 + dg; scan_phase = AT_DASH2; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                AT_DASH2:
                    if (is_dash)
                    begin
                        scan_phase = AT_DAY1; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                AT_DAY1:
                    if (is_dig)
                    begin
                        day_num = dg; scan_phase = AT_DAY2; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                AT_DAY2:
                    if (is_dig)
                    begin
                        day_num = day_num * 10 + dg; scan_phase = AT_DONE; count_byte();
                    end
                    else
                        scan_failed = 1'b1;
                default:
                    ;
            endcase
        end
        if (last)
        begin
            ok = !scan_failed && scan_phase == AT_DONE;
            if (ok && year_mag > (year_neg ? YEAR_MIN_MAG : YEAR_MAX_MAG))
                ok = 1'b0;
            if (ok && (month_num < 1 || month_num > 12))
                ok = 1'b0;
            else if (ok && (day_num < 1 || day_num > month_days(year_mag, month_num)))
                ok = 1'b0;
            if (ok)
            begin
                y = year_neg ? -longint'(year_mag) : longint'(year_mag);
                days = days_from_epoch(y, month_num, day_num);
                res.day  = days[31:0];
                res.ok   = 1'b1;
                res.used = used_bytes[3:0];
            end
            else
            begin
                res.day  = NO_DATE;
                res.ok   = 1'b0;
                res.used = '0;
            end
            clear_scan();
        end
    endtask

    // Offer one byte word, wait for it to be taken, then record any date it completes.
    // Entered and left at a falling edge.
    task automatic put_byte(input logic [7:0] c, input bit last, input bit typed,
                            input date_result_t typed_res);
        bit           got;
        date_result_t res;
        while ($urandom_range(99) < snd_idle)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= last;
        do
            @(posedge clk);
        while (char_stall);
        scan_byte(c, last, got, res);
        if (got)
            pending_dates.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // Append a number as exactly n decimal digits.
    function automatic void push_digits(int unsigned v, int n);
        logic [7:0] dig [$];
        for (int i = 0; i < n; i++)
        begin
            dig.push_front(ZERO_CHAR + 8'(v % 10));
            v = v / 10;
        end
        foreach (dig[i])
            field_bytes.push_back(dig[i]);
    endfunction

    // Build one random field: mostly dates with random content, the rest noise.
    function automatic void make_field();
        int unsigned limits [6] = '{5877640, 5877641, 5877642, 5879609, 5879610, 5879611};
        int unsigned yr;
        int unsigned span;
        int          n;
        int          sel;
        int          k;
        field_bytes.delete();
        if ($urandom_range(99) < 75)
        begin
            if ($urandom_range(4) == 0)
                field_bytes.push_back(DASH_CHAR);
            sel = $urandom_range(9);
            if (sel == 0)
            begin
                n  = 7;
                yr = limits[$urandom_range(5)];
            end
            else if (sel < 4)
            begin
                n = $urandom_range(1, YEAR_DIGITS + 1);
                span = 1;
                for (int i = 0; i < n; i++)
                    span = span * 10;
                yr = $urandom % span;
            end
            else
            begin
                n  = 4;
                yr = $urandom_range(0, 9999);
            end
            push_digits(yr, n);
            field_bytes.push_back(DASH_CHAR);
            push_digits(($urandom_range(9) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(1, 12), 2);
            field_bytes.push_back(DASH_CHAR);
            push_digits(($urandom_range(9) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(1, 31), 2);
            // Trailing text that the date leaves to the caller.
            if ($urandom_range(3) == 0)
            begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    field_bytes.push_back(8'($urandom_range(0, 255)));
            end
            // Broken dates: cut short or one byte spoiled.
            if ($urandom_range(9) == 0)
            begin
                k = $urandom_range(1, field_bytes.size());
                field_bytes = field_bytes[0:k-1];
            end
            if ($urandom_range(9) == 0)
                field_bytes[$urandom_range(0, field_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
        end
        else
        begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
            begin
                sel = $urandom_range(2);
                if (sel == 0)
                    field_bytes.push_back(DASH_CHAR);
                else if (sel == 1)
                    field_bytes.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
                else
                    field_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Output side: stall at random at the rate of the current phase.
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < rcv_idle);

    // Compare every accepted result word with the oldest date owed.
    always @(posedge clk)
    begin : check_results
        date_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("unexpected result word: day_number %0d date_valid %0d chars_used %0d",
                       day_number, date_valid, chars_used);
                err_cnt++;
            end
            else
            begin
                want = pending_dates.pop_front();
                if (day_number !== want.day)
                begin
                    $error("day_number: expected %0d, got %0d", want.day, day_number);
                    err_cnt++;
                end
                if (date_valid !== want.ok)
                begin
                    $error("date_valid: expected %0d, got %0d", want.ok, date_valid);
                    err_cnt++;
                end
                if (chars_used !== want.used)
                begin
                    $error("chars_used: expected %0d, got %0d", want.used, chars_used);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus: directed fields, then random fields under three idling mixes.
    initial
    begin : stimulus
        date_result_t typed_res;
        int           sent;
        int           cut;
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = '0;
        last_char    = 1'b0;
        snd_idle     = 28;
        rcv_idle     = 75;
        clear_scan();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (date_cases[i])
        begin
            typed_res.day  = date_cases[i].day;
            typed_res.ok   = date_cases[i].ok;
            typed_res.used = date_cases[i].used;
            if (date_cases[i].text.len() == 0)
                put_byte(NUL_CHAR, 1'b1, date_cases[i].typed, typed_res);
            else
                for (int j = 0; j < date_cases[i].text.len(); j++)
                    put_byte(date_cases[i].text[j], j == date_cases[i].text.len() - 1,
                             date_cases[i].typed, typed_res);
        end

        sent = 0;
        for (int mix = 0; mix < 3; mix++)
        begin
            snd_idle = (mix == 0) ? 28 : (mix == 1) ? 75 : 0;
            rcv_idle = (mix == 0) ? 75 : (mix == 1) ? 28 : 0;
            cut = (mix + 1) * RANDOM_BYTES / 3;
            while (sent < cut)
            begin
                make_field();
                foreach (field_bytes[i])
                    put_byte(field_bytes[i], i == field_bytes.size() - 1, 1'b0, '0);
                sent += field_bytes.size();
            end
        end
        char_valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray word.
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("iso_date_text_to_day_number_test: clean");
        else
            $display("iso_date_text_to_day_number_test: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("iso_date_text_to_day_number_test: errors");
        $finish;
    end

endmodule
